FILE: rtl/core/pth_pkg.sv
// ----------------------------------------------------------------------------
// Point transform package
// Shared widths, register layout, reset values and the saturation helper.
// ----------------------------------------------------------------------------
package pth_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 48;
	localparam int ELEM_W    = 24;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = COORD_W + ELEM_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int MAG_W     = ACC_W;
	localparam int FRAC_OUT  = 16;
	localparam int NARROW_SH = 12;
	localparam int DIV_STEPS = 32;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;
	localparam int PIPE_D    = DIV_STEPS + 4;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] reg_bank_t;

	typedef struct packed {
		logic               neg;
		logic               wz;
		logic               ovf;
		logic [COORD_W-1:0] q;
		logic [COORD_W-1:0] zres;
	} div_res_t;

	parameter logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		48'd4096, 48'd0, 48'd4096 << 24, 48'd0,
		48'd0, 48'd4096, 48'd0, 48'd4096 << 24
	};

	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;

	function automatic logic [COORD_W-1:0] sat_mag(input logic neg,
		input logic [MAG_W-1:0] mag);
		logic [COORD_W-1:0] low;
		low = mag[COORD_W-1:0];
		if (neg) begin
			if (mag >= {{(MAG_W-COORD_W){1'b0}}, SAT_MIN})
				return SAT_MIN;
			return (~low) + 32'd1;
		end
		if (mag > {{(MAG_W-COORD_W){1'b0}}, SAT_MAX})
			return SAT_MAX;
		return low;
	endfunction

endpackage

FILE: rtl/core/pth_ifs.sv
// ----------------------------------------------------------------------------
// Point transform channels
// Valid/ready channels for the input point and the transformed result.
// ----------------------------------------------------------------------------
interface pth_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	modport source(output valid, in_x, in_y, in_z, input ready);
	modport sink(input valid, in_x, in_y, in_z, output ready);
endinterface

interface pth_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               w_was_zero;
	modport source(output valid, out_x, out_y, out_z, w_was_zero, input ready);
	modport sink(input valid, out_x, out_y, out_z, w_was_zero, output ready);
endinterface

FILE: rtl/core/pth_regs.sv
// ----------------------------------------------------------------------------
// Point transform matrix registers
// APB register file holding the eight packed matrix registers.
// ----------------------------------------------------------------------------
module pth_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pth_pkg::PADDR_W-1:0]   paddr,
	input  logic [pth_pkg::PDATA_W-1:0]   pwdata,
	output logic [pth_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output pth_pkg::reg_bank_t            bank
);

	pth_pkg::reg_bank_t bank_q;
	logic [2:0]         idx;

	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign prdata = {{(pth_pkg::PDATA_W-pth_pkg::REG_W){1'b0}}, bank_q[idx]};
	assign bank   = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pth_pkg::NUM_REGS; i++)
				bank_q[i] <= pth_pkg::REG_RESET[i];
		end else if (psel && penable && pwrite) begin
			bank_q[idx] <= pwdata[pth_pkg::REG_W-1:0];
		end
	end

endmodule

FILE: rtl/core/pth_mac_lane.sv
// ----------------------------------------------------------------------------
// Point transform column lane
// Forms one column of the row-vector product in exact Q30.28.
// ----------------------------------------------------------------------------
module pth_mac_lane (
	input  logic                                clk,
	input  logic [1:0]                          en,
	input  logic signed [pth_pkg::COORD_W-1:0]  x,
	input  logic signed [pth_pkg::COORD_W-1:0]  y,
	input  logic signed [pth_pkg::COORD_W-1:0]  z,
	input  logic signed [pth_pkg::ELEM_W-1:0]   m0,
	input  logic signed [pth_pkg::ELEM_W-1:0]   m1,
	input  logic signed [pth_pkg::ELEM_W-1:0]   m2,
	input  logic signed [pth_pkg::ELEM_W-1:0]   m3,
	output logic signed [pth_pkg::ACC_W-1:0]    acc
);

	localparam int FRAC_SH = pth_pkg::FRAC_OUT;

	logic signed [pth_pkg::PROD_W-1:0]            p0_s1, p1_s1, p2_s1;
	logic signed [pth_pkg::ELEM_W+FRAC_SH-1:0]    t_s1;
	logic signed [pth_pkg::ACC_W-1:0]             acc_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p0_s1 <= x * m0;
			p1_s1 <= y * m1;
			p2_s1 <= z * m2;
			t_s1  <= {m3, {FRAC_SH{1'b0}}};
		end
		if (en[1])
			acc_s2 <= pth_pkg::ACC_W'(p0_s1) + pth_pkg::ACC_W'(p1_s1)
				+ pth_pkg::ACC_W'(p2_s1) + pth_pkg::ACC_W'(t_s1);
	end

	assign acc = acc_s2;

endmodule

FILE: rtl/core/pth_div_lane.sv
// ----------------------------------------------------------------------------
// Point transform divide lane
// Pipelined restoring divider giving one quotient bit per stage, with the
// zero-w bypass value formed alongside.
// ----------------------------------------------------------------------------
module pth_div_lane (
	input  logic                               clk,
	input  logic [pth_pkg::DIV_STEPS:0]        en,
	input  logic signed [pth_pkg::ACC_W-1:0]   num,
	input  logic signed [pth_pkg::ACC_W-1:0]   den,
	output pth_pkg::div_res_t                  res
);

	localparam int MW = pth_pkg::MAG_W;
	localparam int FW = pth_pkg::FRAC_OUT;
	localparam int NS = pth_pkg::DIV_STEPS;
	localparam int CW = pth_pkg::COORD_W;

	logic          neg_s3, wz_s3;
	logic [MW-1:0] n_s3, d_s3;

	logic [MW-1:0] rem_sn  [NS];
	logic [MW-1:0] d_sn    [NS];
	logic [FW-1:0] low_sn  [NS];
	logic [CW-1:0] q_sn    [NS];
	logic [CW-1:0] zres_sn [NS];
	logic          ovf_sn  [NS];
	logic          neg_sn  [NS];
	logic          wz_sn   [NS];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s3 <= num[pth_pkg::ACC_W-1] ^ den[pth_pkg::ACC_W-1];
			wz_s3  <= (den == '0);
			n_s3   <= num[pth_pkg::ACC_W-1] ? MW'(-num) : MW'(num);
			d_s3   <= den[pth_pkg::ACC_W-1] ? MW'(-den) : MW'(den);
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_step
		logic [MW-1:0] rin, din;
		logic [FW-1:0] lowin;
		logic [CW-1:0] qin, zin;
		logic          oin, nin, win;
		logic [MW:0]   t;
		logic          ge;

		if (j == 0) begin : g_first
			assign rin   = n_s3 >> FW;
			assign din   = d_s3;
			assign lowin = n_s3[FW-1:0];
			assign qin   = '0;
			assign oin   = ((n_s3 >> FW) >= d_s3);
			assign nin   = neg_s3;
			assign win   = wz_s3;
			assign zin   = pth_pkg::sat_mag(neg_s3, n_s3 >> pth_pkg::NARROW_SH);
		end else begin : g_next
			assign rin   = rem_sn[j-1];
			assign din   = d_sn[j-1];
			assign lowin = low_sn[j-1];
			assign qin   = q_sn[j-1];
			assign oin   = ovf_sn[j-1];
			assign nin   = neg_sn[j-1];
			assign win   = wz_sn[j-1];
			assign zin   = zres_sn[j-1];
		end

		assign t  = {rin, lowin[FW-1]};
		assign ge = (t >= {1'b0, din});

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				rem_sn[j]  <= ge ? MW'(t - {1'b0, din}) : MW'(t);
				d_sn[j]    <= din;
				low_sn[j]  <= {lowin[FW-2:0], 1'b0};
				q_sn[j]    <= {qin[CW-2:0], ge};
				ovf_sn[j]  <= oin;
				neg_sn[j]  <= nin;
				wz_sn[j]   <= win;
				zres_sn[j] <= zin;
			end
		end
	end

	assign res.neg  = neg_sn[NS-1];
	assign res.wz   = wz_sn[NS-1];
	assign res.ovf  = ovf_sn[NS-1];
	assign res.q    = q_sn[NS-1];
	assign res.zres = zres_sn[NS-1];

endmodule

FILE: rtl/core/point_transform_homogeneous.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform
// Multiplies a Q16.16 point by a 4x4 Q12.12 matrix and divides by w.
//
//  Channel   Kind       Carries
//  point     sink       in_x, in_y, in_z
//  result    source     out_x, out_y, out_z, w_was_zero
//  APB       slave      eight 48-bit matrix registers at 8-byte steps
//
// One transfer is accepted every cycle unless a result-side stall has filled
// every stage; the 32-stage divider pipeline yields one quotient bit per stage.
// Stalls on the result side fill empty stages first; the input stalls only
// once every stage holds an item. Reset empties the pipeline and loads the
// identity matrix.
// ----------------------------------------------------------------------------
module point_transform_homogeneous (
	input  logic                          clk,
	input  logic                          arst_n,
	pth_point_if.sink                     point,
	pth_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pth_pkg::PADDR_W-1:0]   paddr,
	input  logic [pth_pkg::PDATA_W-1:0]   pwdata,
	output logic [pth_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int D  = pth_pkg::PIPE_D;
	localparam int EW = pth_pkg::ELEM_W;

	pth_pkg::reg_bank_t          bank;
	logic [D-1:0]                v_q, en;
	logic signed [pth_pkg::ACC_W-1:0] acc [4];
	pth_pkg::div_res_t           dres [3];
	logic [31:0]                 fin [3];
	logic [31:0]                 out_x_q, out_y_q, out_z_q;
	logic                        wz_q;

	pth_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .bank
	);

	always_comb begin
		en[D-1] = !v_q[D-1] || result.ready;
		for (int k = D - 2; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign point.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= point.valid;
			for (int k = 1; k < D; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_col
		localparam int SH = (c % 2) * EW;
		pth_mac_lane u_mac (
			.clk,
			.en  (en[1:0]),
			.x   (point.in_x),
			.y   (point.in_y),
			.z   (point.in_z),
			.m0  (bank[c / 2][SH +: EW]),
			.m1  (bank[2 + c / 2][SH +: EW]),
			.m2  (bank[4 + c / 2][SH +: EW]),
			.m3  (bank[6 + c / 2][SH +: EW]),
			.acc (acc[c])
		);
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		pth_div_lane u_div (
			.clk,
			.en  (en[D-2:2]),
			.num (acc[c]),
			.den (acc[3]),
			.res (dres[c])
		);
		always_comb begin
			if (dres[c].wz)
				fin[c] = dres[c].zres;
			else if (dres[c].ovf)
				fin[c] = dres[c].neg ? pth_pkg::SAT_MIN : pth_pkg::SAT_MAX;
			else
				fin[c] = pth_pkg::sat_mag(dres[c].neg,
					{{(pth_pkg::MAG_W-32){1'b0}}, dres[c].q});
		end
	end

	always_ff @(posedge clk) begin
		if (en[D-1]) begin
			out_x_q <= fin[0];
			out_y_q <= fin[1];
			out_z_q <= fin[2];
			wz_q    <= dres[0].wz;
		end
	end

	assign result.valid      = v_q[D-1];
	assign result.out_x      = out_x_q;
	assign result.out_y      = out_y_q;
	assign result.out_z      = out_z_q;
	assign result.w_was_zero = wz_q;

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[D-1] |-> point.ready)
		else $error("input refused with an empty output stage");

	a_full_when_refused: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (&v_q))
		else $error("input refused while a stage is empty");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[D-2] |-> (dres[0].wz == dres[1].wz && dres[1].wz == dres[2].wz))
		else $error("divide lanes disagree on zero w");

endmodule
